/* design/sdtq_pkg.sv */
package sdtq_pkg;

   localparam int NUM_TIMERS   = 8;
   localparam int ID_BITS      = 3;
   localparam int TIME_BITS    = 48;
   localparam int REM_BITS     = TIME_BITS;
   localparam int DELAY_BITS   = 24;
   localparam int ELAPSED_BITS = 16;
   localparam int US_PER_MS    = 1000;
   localparam int MS_BITS      = $clog2(US_PER_MS + 1);
   localparam int PROD_BITS    = DELAY_BITS + MS_BITS;

   typedef enum logic [2:0] {
      OP_TICK           = 3'd0,
      OP_ARM            = 3'd1,
      OP_CANCEL         = 3'd2,
      OP_QUERY_ARMED    = 3'd3,
      OP_QUERY_EARLIEST = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_EXPIRED = 2'd0,
      KIND_ARMED   = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_CANCEL = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_POP    = 2'd3
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARM_ADD,
      ST_CANCEL,
      ST_INSERT,
      ST_TICK
   } state_type;

   typedef struct packed {
      logic [2:0]              op;
      logic [ID_BITS-1:0]      timer_id;
      logic [DELAY_BITS-1:0]   delay_ms;
      logic [ELAPSED_BITS-1:0] elapsed_us;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [ID_BITS-1:0]  fired_id;
      logic                armed;
      logic                any_pending;
      logic [REM_BITS-1:0] remaining_us;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic                 valid;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] deadline;
   } entry_type;

   typedef struct packed {
      cell_cmd_type         cmd;
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] deadline;
      logic                 ins_enable;
   } cell_ctrl_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction

endpackage

/* design/sdtq_cell.sv */
module sdtq_cell import sdtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     left_entry,
   input  logic          left_go,
   input  entry_type     right_entry,
   input  logic          rm_in,
   output entry_type     entry,
   output logic          go,
   output logic          rm_out,
   output logic          hit
);

   entry_type entry_ff;
   entry_type entry_in;

   assign entry  = entry_ff;
   assign hit    = entry_ff.valid && (entry_ff.id == ctrl.id);
   // Deadlines are sorted and empty cells sit at the tail, so go is monotonic along the row.
   assign go     = !entry_ff.valid || (ctrl.deadline < entry_ff.deadline);
   assign rm_out = rm_in || hit;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.cmd)
         CELL_CANCEL: begin
            if (rm_out) begin
               entry_in = right_entry;
            end
         end
         CELL_INSERT: begin
            if (ctrl.ins_enable && go) begin
               if (left_go) begin
                  entry_in = left_entry;
               end else begin
                  entry_in.valid    = 1'b1;
                  entry_in.id       = ctrl.id;
                  entry_in.deadline = ctrl.deadline;
               end
            end
         end
         CELL_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.id       <= entry_in.id;
      entry_ff.deadline <= entry_in.deadline;
   end

endmodule

/* design/sorted_deadline_timer_queue.sv */
// Sorted queue of one-shot timers held in a row of cells, earliest deadline in the first cell,
// beside a saturating microsecond clock. A query's result is loaded into the result register
// as the word is accepted, and the next word may follow as soon as that register is free. A
// cancel makes one pass of the row, which removes the entry and closes the gap. An arm goes
// in steps: the delay is scaled to microseconds as the word is accepted, added to the clock,
// then the row cancels the old entry and shifts open a place for the new one. A tick advances
// the clock as it is accepted; then the head cell is compared against the clock and popped,
// one expired timer per cycle as fast as the result side takes words, until none is due.
// Reset clears the state, the clock, the result valid flag and the cell valid flags only.
module sorted_deadline_timer_queue import sdtq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   state_type              state_ff, state_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [TIME_BITS-1:0]   dl_ff, dl_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic                   arm_ff, arm_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_word_ff;
   rsp_type                rsp_next;
   logic                   rsp_load;
   logic                   out_free;
   logic                   req_take;
   cell_cmd_type           cmd;
   cell_ctrl_type          ctrl;
   logic [TIME_BITS-1:0]   diff;

   entry_type              cell_q     [NUM_TIMERS];
   entry_type              next_entry [NUM_TIMERS];
   entry_type              prev_entry [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]  go_vec;
   logic [NUM_TIMERS-1:0]  prev_go;
   logic [NUM_TIMERS-1:0]  rm_vec;
   logic [NUM_TIMERS-1:0]  rm_prev;
   logic [NUM_TIMERS-1:0]  hit_vec;
   logic [NUM_TIMERS-1:0]  valid_vec;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign ctrl.cmd        = cmd;
   assign ctrl.id         = (state_ff == ST_IDLE) ? req_word.timer_id : id_ff;
   assign ctrl.deadline   = dl_ff;
   // A full row takes no new entry; the cancel pass has already freed a place if the id was queued.
   assign ctrl.ins_enable = !cell_q[NUM_TIMERS-1].valid;

   for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign prev_entry[k] = '0;
         assign prev_go[k]    = 1'b0;
         assign rm_prev[k]    = 1'b0;
      end else begin : g_body
         assign prev_entry[k] = cell_q[k-1];
         assign prev_go[k]    = go_vec[k-1];
         assign rm_prev[k]    = rm_vec[k-1];
      end
      if (k == NUM_TIMERS - 1) begin : g_tail
         assign next_entry[k] = '0;
      end else begin : g_mid
         assign next_entry[k] = cell_q[k+1];
      end
      assign valid_vec[k] = cell_q[k].valid;

      sdtq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_entry  (prev_entry[k]),
         .left_go     (prev_go[k]),
         .right_entry (next_entry[k]),
         .rm_in       (rm_prev[k]),
         .entry       (cell_q[k]),
         .go          (go_vec[k]),
         .rm_out      (rm_vec[k]),
         .hit         (hit_vec[k])
      );
   end

   assign diff = cell_q[0].deadline - now_ff;

   always_comb begin
      state_in = state_ff;
      now_in   = now_ff;
      prod_in  = prod_ff;
      dl_in    = dl_ff;
      id_in    = id_ff;
      arm_in   = arm_ff;
      rsp_load = 1'b0;
      rsp_next = '0;
      cmd      = CELL_HOLD;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_word.op)
                  OP_TICK: begin
                     now_in   = sat_add(now_ff, TIME_BITS'(req_word.elapsed_us));
                     state_in = ST_TICK;
                  end
                  OP_ARM: begin
                     prod_in  = PROD_BITS'(req_word.delay_ms) * PROD_BITS'(US_PER_MS);
                     id_in    = req_word.timer_id;
                     arm_in   = 1'b1;
                     state_in = ST_ARM_ADD;
                  end
                  OP_CANCEL: begin
                     id_in    = req_word.timer_id;
                     arm_in   = 1'b0;
                     state_in = ST_CANCEL;
                  end
                  OP_QUERY_ARMED: begin
                     rsp_load             = 1'b1;
                     rsp_next.kind        = KIND_ARMED;
                     rsp_next.fired_id    = req_word.timer_id;
                     rsp_next.armed       = |hit_vec;
                     rsp_next.any_pending = cell_q[0].valid;
                     rsp_next.last        = 1'b1;
                  end
                  OP_QUERY_EARLIEST: begin
                     rsp_load      = 1'b1;
                     rsp_next.kind = KIND_TIMEOUT;
                     rsp_next.last = 1'b1;
                     if (cell_q[0].valid) begin
                        rsp_next.fired_id    = cell_q[0].id;
                        rsp_next.any_pending = 1'b1;
                        if (cell_q[0].deadline > now_ff) begin
                           rsp_next.remaining_us = REM_BITS'(diff);
                        end
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ARM_ADD: begin
            dl_in    = sat_add(now_ff, TIME_BITS'(prod_ff));
            state_in = ST_CANCEL;
         end
         ST_CANCEL: begin
            cmd      = CELL_CANCEL;
            state_in = arm_ff ? ST_INSERT : ST_IDLE;
         end
         ST_INSERT: begin
            cmd      = CELL_INSERT;
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            if (cell_q[0].valid && (cell_q[0].deadline < now_ff)) begin
               if (out_free) begin
                  cmd                  = CELL_POP;
                  rsp_load             = 1'b1;
                  rsp_next.kind        = KIND_EXPIRED;
                  rsp_next.fired_id    = cell_q[0].id;
                  rsp_next.any_pending = next_entry[0].valid;
                  rsp_next.last        = !(next_entry[0].valid &&
                                           (next_entry[0].deadline < now_ff));
                  if (rsp_next.last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
      prod_ff <= prod_in;
      dl_ff   <= dl_in;
      id_ff   <= id_in;
      arm_ff  <= arm_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_next;
      end
   end

   logic order_ok;

   always_comb begin
      order_ok = 1'b1;
      for (int k = 0; k < NUM_TIMERS - 1; k++) begin
         if (cell_q[k+1].valid && (cell_q[k].deadline > cell_q[k+1].deadline)) begin
            order_ok = 1'b0;
         end
      end
   end

   // Occupied cells always form an unbroken run from the head of the row.
   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + NUM_TIMERS'(1)) & valid_vec) == '0)
      else $error("queued timers do not form a packed run from the head");

   a_cells_sorted: assert property (@(posedge clock) disable iff (reset) order_ok)
      else $error("queued deadlines are out of order");

   a_pop_removes_one: assert property (@(posedge clock) disable iff (reset)
      (cmd == CELL_POP) |=> ($countones(valid_vec) + 1 == $past($countones(valid_vec))))
      else $error("an expiry did not remove exactly one timer");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_word_ff)))
      else $error("a stalled result was overwritten");

endmodule

/* tb/sorted_deadline_timer_queue_tb.sv */
module sorted_deadline_timer_queue_tb;
   import sdtq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int              RANDOM_WORDS  = 300;
   localparam int              CYCLE_LIMIT   = 2000000;
   localparam int              TAIL_CYCLES   = 40;
   localparam int              LONG_HOLD     = 500;
   localparam int              HOLD_AFTER    = 40;
   localparam logic [2:0]      OP_LAST_KNOWN = OP_QUERY_EARLIEST;

   typedef struct {
      req_type word;
      bit      drain_first;
   } pending_word_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   // Shadow of the timer queue, advanced whenever a request word is accepted.
   logic [TIME_BITS-1:0] now_us;
   logic [TIME_BITS-1:0] slot_deadline [NUM_TIMERS];
   logic [ID_BITS-1:0]   queued_ids [$];

   pending_word_type stim_q [$];
   rsp_type          expected_rsps [$];

   int errors        = 0;
   int words_sent    = 0;
   int ignored_words = 0;
   int results_seen  = 0;
   int expiries_seen = 0;
   int cycle_count   = 0;

   sorted_deadline_timer_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [TIME_BITS-1:0] add_capped(input logic [TIME_BITS-1:0] a,
                                                       input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total > {1'b0, {TIME_BITS{1'b1}}})
         return {TIME_BITS{1'b1}};
      return total[TIME_BITS-1:0];
   endfunction

   function automatic int slot_position(input logic [ID_BITS-1:0] id);
      for (int k = 0; k < queued_ids.size(); k++)
         if (queued_ids[k] == id)
            return k;
      return -1;
   endfunction

   function automatic bit head_due();
      return queued_ids.size() > 0 && slot_deadline[queued_ids[0]] < now_us;
   endfunction

   task automatic predict_timer_word(input req_type w);
      rsp_type              r;
      logic [TIME_BITS-1:0] dl;
      int                   pos;
      int                   n;
      r = '0;
      case (w.op)
         OP_TICK: begin
            now_us = add_capped(now_us, TIME_BITS'(w.elapsed_us));
            n = 0;
            while (n < NUM_TIMERS && head_due()) begin
               r = '0;
               r.kind = KIND_EXPIRED;
               r.fired_id = queued_ids.pop_front();
               r.any_pending = queued_ids.size() > 0;
               n++;
               r.last = !(n < NUM_TIMERS && head_due());
               expected_rsps.push_back(r);
            end
         end
         OP_ARM: begin
            pos = slot_position(w.timer_id);
            if (pos >= 0)
               queued_ids.delete(pos);
            if (queued_ids.size() < NUM_TIMERS) begin
               dl = add_capped(now_us, TIME_BITS'(w.delay_ms) * TIME_BITS'(US_PER_MS));
               slot_deadline[w.timer_id] = dl;
               // A new timer goes behind every queued timer with the same deadline.
               pos = queued_ids.size();
               for (int k = 0; k < queued_ids.size(); k++)
                  if (pos == queued_ids.size() && dl < slot_deadline[queued_ids[k]])
                     pos = k;
               queued_ids.insert(pos, w.timer_id);
            end
         end
         OP_CANCEL: begin
            pos = slot_position(w.timer_id);
            if (pos >= 0)
               queued_ids.delete(pos);
         end
         OP_QUERY_ARMED: begin
            r.kind = KIND_ARMED;
            r.fired_id = w.timer_id;
            r.armed = slot_position(w.timer_id) >= 0;
            r.any_pending = queued_ids.size() > 0;
            r.last = 1'b1;
            expected_rsps.push_back(r);
         end
         OP_QUERY_EARLIEST: begin
            r.kind = KIND_TIMEOUT;
            r.last = 1'b1;
            if (queued_ids.size() > 0) begin
               r.fired_id = queued_ids[0];
               r.any_pending = 1'b1;
               dl = slot_deadline[queued_ids[0]];
               if (dl > now_us)
                  r.remaining_us = REM_BITS'(dl - now_us);
            end
            expected_rsps.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   function automatic req_type make_word(input logic [2:0] op, input int id, input int delay,
                                         input int elapsed);
      req_type w;
      w.op = op;
      w.timer_id = ID_BITS'(id);
      w.delay_ms = DELAY_BITS'(delay);
      w.elapsed_us = ELAPSED_BITS'(elapsed);
      return w;
   endfunction

   task automatic queue_word(input req_type w, input bit drain_first = 1'b0);
      pending_word_type p;
      p.word = w;
      p.drain_first = drain_first;
      stim_q.push_back(p);
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic build_stimulus();
      req_type w;
      int      roll;
      int      counted;
      // Directed words: empty queries, a tick that fires nothing, cancelling an idle timer,
      // extreme fields, equal deadlines, re-arming, unknown opcodes and a full queue expiring.
      queue_word(make_word(OP_QUERY_EARLIEST, 5, 0, 0));
      queue_word(make_word(OP_QUERY_ARMED, 0, 0, 0));
      queue_word(make_word(OP_TICK, 0, 0, 0));
      queue_word(make_word(OP_CANCEL, 3, 0, 0));
      queue_word(make_word(OP_ARM, 7, 24'hFFFFFF, 16'hFFFF));
      queue_word(make_word(OP_ARM, 0, 0, 0));
      queue_word(make_word(OP_ARM, 1, 0, 0));
      queue_word(make_word(OP_ARM, 2, 5, 0));
      queue_word(make_word(OP_QUERY_ARMED, 7, 0, 0));
      queue_word(make_word(OP_QUERY_EARLIEST, 0, 0, 0));
      queue_word(make_word(OP_TICK, 0, 0, 0));
      queue_word(make_word(OP_TICK, 0, 0, 1));
      queue_word(make_word(OP_ARM, 2, 3, 0));
      queue_word(make_word(OP_QUERY_EARLIEST, 0, 0, 0));
      queue_word(make_word(OP_CANCEL, 7, 0, 0));
      queue_word(make_word(OP_QUERY_ARMED, 7, 0, 0));
      queue_word(make_word(OP_LAST_KNOWN + 3'd1, 7, 24'hFFFFFF, 16'hFFFF));
      queue_word(make_word(OP_LAST_KNOWN + 3'd3, 2, 0, 0));
      queue_word(make_word(OP_TICK, 7, 24'hFFFFFF, 16'hFFFF));
      for (int id = 0; id < NUM_TIMERS; id++)
         queue_word(make_word(OP_ARM, id, 1, 0));
      queue_word(make_word(OP_TICK, 0, 0, 16'hFFFF), 1'b1);

      counted = 0;
      while (counted < RANDOM_WORDS) begin
         w = make_word(OP_TICK, $urandom_range(0, 7), $urandom_range(0, 24'hFFFFFF),
                       $urandom_range(0, 16'hFFFF));
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            w.op = OP_ARM;
            if ($urandom_range(0, 4) != 0)
               w.delay_ms = DELAY_BITS'($urandom_range(0, 60));
         end else if (roll < 60) begin
            w.op = OP_TICK;
            if ($urandom_range(0, 7) != 0)
               w.elapsed_us = ELAPSED_BITS'($urandom_range(0, 20000));
         end else if (roll < 70) begin
            w.op = OP_CANCEL;
         end else if (roll < 82) begin
            w.op = OP_QUERY_ARMED;
         end else if (roll < 94) begin
            w.op = OP_QUERY_EARLIEST;
         end else begin
            w.op = OP_LAST_KNOWN + 3'($urandom_range(1, 3));
         end
         if (w.op > OP_LAST_KNOWN) begin
            queue_word(w);
         end else begin
            queue_word(w, counted % 90 == 89);
            counted++;
         end
      end
   endtask

   // Request side: offers the next word once the previous one is taken and its gap has passed.
   int req_gap   = 0;
   int calm_left = 0;
   always @(posedge clock) begin
      pending_word_type p;
      logic offer;
      logic holding;
      if (!reset) begin
         holding = req_valid;
         if (req_valid && !req_stall) begin
            predict_timer_word(req_word);
            words_sent++;
            if (req_word.op > OP_LAST_KNOWN)
               ignored_words++;
            holding = 1'b0;
         end
         offer = holding;
         if (!holding) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (stim_q.size() > 0 &&
                         !(stim_q[0].drain_first && expected_rsps.size() > 0)) begin
               p = stim_q.pop_front();
               req_word <= p.word;
               offer = 1'b1;
               if (calm_left > 0) begin
                  calm_left--;
                  req_gap = 0;
               end else begin
                  req_gap = pick_gap();
                  if ($urandom_range(0, 29) == 0)
                     calm_left = 30;
               end
            end
         end
         req_valid <= offer;
      end
   end

   // Result side: checks each accepted word against the oldest prediction.
   int  stall_left     = 0;
   int  free_left      = 0;
   bit  long_hold_done = 1'b0;
   always @(posedge clock) begin
      rsp_type want;
      logic    hold;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_word.kind == KIND_EXPIRED)
               expiries_seen++;
            if (expected_rsps.size() == 0) begin
               $error("result word with nothing expected: %p", rsp_word);
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_word.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_word.kind);
                  errors++;
               end
               if (rsp_word.fired_id !== want.fired_id) begin
                  $error("fired_id: expected %0d, got %0d", want.fired_id, rsp_word.fired_id);
                  errors++;
               end
               if (rsp_word.armed !== want.armed) begin
                  $error("armed: expected %0d, got %0d", want.armed, rsp_word.armed);
                  errors++;
               end
               if (rsp_word.any_pending !== want.any_pending) begin
                  $error("any_pending: expected %0d, got %0d", want.any_pending,
                         rsp_word.any_pending);
                  errors++;
               end
               if (rsp_word.remaining_us !== want.remaining_us) begin
                  $error("remaining_us: expected %0d, got %0d", want.remaining_us,
                         rsp_word.remaining_us);
                  errors++;
               end
               if (rsp_word.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_word.last);
                  errors++;
               end
            end
         end
         // One long hold so that the queue backs up into the request side.
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD;
            free_left = 0;
         end
         if (stall_left > 0) begin
            hold = 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            hold = 1'b0;
            free_left--;
         end else begin
            hold = 1'b0;
            stall_left = pick_gap();
            free_left = ($urandom_range(0, 15) == 0) ? 60 : $urandom_range(0, 6);
         end
         rsp_stall <= hold;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timed out with %0d results still expected", expected_rsps.size());
         $display("sorted_deadline_timer_queue_tb: FAIL");
         $finish;
      end
   end

   initial begin
      now_us = '0;
      foreach (slot_deadline[i])
         slot_deadline[i] = '0;
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do
         @(posedge clock);
      while (stim_q.size() > 0 || req_valid || expected_rsps.size() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d request words (%0d with unknown opcodes) and checked %0d result words,",
               words_sent, ignored_words, results_seen);
      $display("of which %0d were expiries, under random gaps, stalls and one long hold.",
               expiries_seen);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("sorted_deadline_timer_queue_tb: PASS");
      else
         $display("sorted_deadline_timer_queue_tb: FAIL");
      $finish;
   end

endmodule
